>>> rtl/core/arwt_pkg.sv
package arwt_pkg;

    // Field widths
    localparam int SLOT_W      = 4;
    localparam int SEQ_W       = 16;
    localparam int LEN_W       = 8;
    localparam int MAXLEN_W    = 4;
    localparam int VERDICT_W   = 3;
    localparam int WINDOW_BITS = 64;
    localparam int SHIFT_W     = 6;
    localparam int PAST_W      = 5;
    localparam int DIFF_W      = SEQ_W + 1;

    // Defaults
    localparam int                  DEF_SENDER_SLOTS = 16;
    localparam logic [MAXLEN_W-1:0] MAXLEN_RESET     = 4'd7;

    // Request queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Verdict codes
    localparam logic [VERDICT_W-1:0] V_NEW    = 3'd0;
    localparam logic [VERDICT_W-1:0] V_OOO    = 3'd1;
    localparam logic [VERDICT_W-1:0] V_RESET  = 3'd2;
    localparam logic [VERDICT_W-1:0] V_DUP    = 3'd3;
    localparam logic [VERDICT_W-1:0] V_BADLEN = 3'd4;

    // Classified request handed from front to back
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [SEQ_W-1:0]  seq;
        logic              bad_slot;
        logic              bad_len;
    } req_t;

    // One sender table entry
    typedef struct packed {
        logic [SEQ_W-1:0]       highest;
        logic [WINDOW_BITS-1:0] bitmap;
    } entry_t;

    // Queue handshake towards the back
    typedef struct packed {
        logic valid;
        req_t req;
    } queue_out_t;

    typedef enum logic [0:0] {
        B_IDLE,
        B_EXEC
    } back_state_t;

endpackage

>>> rtl/core/arwt_front.sv
module arwt_front #(
    parameter int SENDER_SLOTS = arwt_pkg::DEF_SENDER_SLOTS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [arwt_pkg::MAXLEN_W-1:0] cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [arwt_pkg::SLOT_W-1:0]   s_sender_slot,
    input  logic [arwt_pkg::SEQ_W-1:0]    s_seq_number,
    input  logic [arwt_pkg::LEN_W-1:0]    s_payload_len,
    output arwt_pkg::queue_out_t          q_out,
    input  logic                          q_pop
);
    import arwt_pkg::*;

    logic [MAXLEN_W-1:0] max_len_reg;
    req_t                q_mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                push;
    logic                pop;
    req_t                req_in;

    // Hold the payload length limit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= MAXLEN_RESET;
        end else if (cfg_wr_en) begin
            max_len_reg <= cfg_wr_data;
        end
    end

    // Classify the incoming request
    always_comb begin
        req_in.slot     = s_sender_slot;
        req_in.seq      = s_seq_number;
        req_in.bad_slot = (32'(s_sender_slot) >= 32'(SENDER_SLOTS));
        req_in.bad_len  = (s_payload_len > LEN_W'(max_len_reg));
    end

    assign s_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && (count_reg != '0);

    assign q_out.valid = (count_reg != '0);
    assign q_out.req   = q_mem_reg[rd_ptr_reg];

    // Advance occupancy
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Store queued requests
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= req_in;
        end
    end

endmodule

>>> rtl/core/arwt_back.sv
module arwt_back #(
    parameter int SENDER_SLOTS = arwt_pkg::DEF_SENDER_SLOTS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  arwt_pkg::queue_out_t           q_in,
    output logic                           q_pop,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [arwt_pkg::VERDICT_W-1:0] m_verdict,
    output logic [arwt_pkg::SEQ_W-1:0]     m_highest_after
);
    import arwt_pkg::*;

    localparam int IDX_W = (SENDER_SLOTS > 1) ? $clog2(SENDER_SLOTS) : 1;

    back_state_t          state_reg;
    back_state_t          state_next;
    entry_t               mem [SENDER_SLOTS];
    logic [SENDER_SLOTS-1:0] valid_reg;
    entry_t               rd_reg;
    logic                 rd_valid_reg;
    req_t                 cur_reg;
    logic [IDX_W-1:0]     cur_idx_reg;
    logic [IDX_W-1:0]     q_idx;
    logic [IDX_W+SLOT_W-1:0] slot_ext;
    logic                 rd_en;
    logic                 fire;
    logic                 mem_we;

    logic                 m_valid_reg;
    logic [VERDICT_W-1:0] verdict_reg;
    logic [SEQ_W-1:0]     highest_reg;

    logic [SEQ_W-1:0]       hi;
    logic [WINDOW_BITS-1:0] bm;
    logic [DIFF_W-1:0]      diff;
    logic [DIFF_W-1:0]      back_dist;
    logic                   upd;
    logic [VERDICT_W-1:0]   verdict;
    entry_t                 new_entry;

    // Map the slot to a table index; out of range slots read entry 0
    assign slot_ext = {{IDX_W{1'b0}}, q_in.req.slot};
    assign q_idx    = q_in.req.bad_slot ? '0 : slot_ext[IDX_W-1:0];

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: begin
                if (q_in.valid) begin
                    state_next = B_EXEC;
                end
            end
            B_EXEC: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        rd_en = 1'b0;
        fire  = 1'b0;
        unique case (state_reg)
            B_IDLE: rd_en = q_in.valid;
            B_EXEC: fire  = !m_valid_reg || m_ready;
            default: begin
                rd_en = 1'b0;
                fire  = 1'b0;
            end
        endcase
    end

    assign q_pop  = rd_en;
    assign mem_we = fire && upd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Table memory: registered read, single write
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[cur_idx_reg] <= new_entry;
        end
        if (rd_en) begin
            rd_reg <= mem[q_idx];
        end
    end

    // Entry valid bits; an unwritten entry reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (mem_we) begin
            valid_reg[cur_idx_reg] <= 1'b1;
        end
    end

    // Hold the request under execution
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            cur_reg      <= q_in.req;
            cur_idx_reg  <= q_idx;
            rd_valid_reg <= valid_reg[q_idx];
        end
    end

    // Window check and update
    always_comb begin
        hi        = rd_valid_reg ? rd_reg.highest : '0;
        bm        = rd_valid_reg ? rd_reg.bitmap : '0;
        diff      = {1'b0, cur_reg.seq} - {1'b0, hi};
        back_dist = -diff;
        upd       = 1'b0;
        verdict   = V_DUP;
        new_entry.highest = hi;
        new_entry.bitmap  = bm;
        if (cur_reg.bad_slot) begin
            verdict           = V_BADLEN;
            new_entry.highest = '0;
        end else if (cur_reg.bad_len) begin
            verdict = V_BADLEN;
        end else if (!diff[DIFF_W-1] && (diff != '0)) begin
            // Advance the window
            upd               = 1'b1;
            new_entry.highest = cur_reg.seq;
            if (diff < DIFF_W'(WINDOW_BITS)) begin
                new_entry.bitmap = (bm << diff[SHIFT_W-1:0]) | WINDOW_BITS'(1);
                verdict          = V_NEW;
            end else begin
                new_entry.bitmap = WINDOW_BITS'(1);
                verdict          = V_RESET;
            end
        end else if (diff == '0) begin
            verdict = V_DUP;
        end else if (back_dist < DIFF_W'(32)) begin
            // Recent past: test and mark the bit
            if (bm[back_dist[PAST_W-1:0]]) begin
                verdict = V_DUP;
            end else begin
                upd                                  = 1'b1;
                new_entry.bitmap[back_dist[PAST_W-1:0]] = 1'b1;
                verdict                              = V_OOO;
            end
        end else begin
            // Far past: sender reboot
            upd               = 1'b1;
            new_entry.highest = cur_reg.seq;
            new_entry.bitmap  = WINDOW_BITS'(1);
            verdict           = V_RESET;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            verdict_reg <= verdict;
            highest_reg <= new_entry.highest;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_verdict       = verdict_reg;
    assign m_highest_after = highest_reg;

endmodule

>>> rtl/core/anti_replay_window_table.sv
// Channel   | Direction | Ports
// ----------+-----------+------------------------------------------------------
// request   | in        | s_valid, s_ready, s_sender_slot, s_seq_number,
//           |           | s_payload_len
// result    | out       | m_valid, m_ready, m_verdict, m_highest_after
// config    | in        | cfg_wr_en, cfg_wr_data (max_payload_len)
//
// In the back end each request first reads the sender's table entry from the
// memory (registered read), then updates the entry and writes it back.
// A result is held in the output register until m_ready; the front queue holds
// two requests while the back end or the result side stalls.
// Reset is synchronous; the table is cleared through per-entry valid bits, so
// there is no clearing pass.
module anti_replay_window_table #(
    parameter int SENDER_SLOTS = arwt_pkg::DEF_SENDER_SLOTS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [arwt_pkg::MAXLEN_W-1:0]  cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [arwt_pkg::SLOT_W-1:0]    s_sender_slot,
    input  logic [arwt_pkg::SEQ_W-1:0]     s_seq_number,
    input  logic [arwt_pkg::LEN_W-1:0]     s_payload_len,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [arwt_pkg::VERDICT_W-1:0] m_verdict,
    output logic [arwt_pkg::SEQ_W-1:0]     m_highest_after
);
    import arwt_pkg::*;

    queue_out_t q_out;
    logic       q_pop;

    // Accept and classify
    arwt_front #(
        .SENDER_SLOTS (SENDER_SLOTS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sender_slot (s_sender_slot),
        .s_seq_number  (s_seq_number),
        .s_payload_len (s_payload_len),
        .q_out         (q_out),
        .q_pop         (q_pop)
    );

    // Table update and result
    arwt_back #(
        .SENDER_SLOTS (SENDER_SLOTS)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_in            (q_out),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_verdict       (m_verdict),
        .m_highest_after (m_highest_after)
    );

    // Output is empty straight after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A new highest sequence is always above zero
    a_new_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_verdict == V_NEW)) |-> (m_highest_after != '0))
        else $error("new highest verdict with zero sequence");

    // A fresh result stems from a request that the queue held
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(m_valid) && $past(aresetn, 2)) |-> $past(q_out.valid, 2))
        else $error("result without queued request");

    // The back end only pops a non-empty queue
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_out.valid)
        else $error("pop from empty queue");

endmodule
